@@ hdl/cbconv_pkg.sv @@
// Shared types and constants of the clamped-border 3x3 convolution block.
`default_nettype none

package cbconv_pkg;

   localparam int PIXEL_BITS    = 16;
   localparam int COEF_BITS     = 16;
   localparam int PROD_BITS     = 2 * PIXEL_BITS;
   localparam int ROW_SUM_BITS  = PROD_BITS + 2;
   localparam int SUM_BITS      = 36;
   localparam int OUT_POS_BITS  = 10;
   localparam int SIZE_BITS     = 11;
   localparam int COEF_ROW_BITS = 3 * COEF_BITS;
   localparam int CSR_DATA_BITS = COEF_ROW_BITS;
   localparam int CSR_ADDR_BITS = 3;
   localparam int TAPS          = 3;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_COEF_TOP     = 3'd0,
      CSR_COEF_MID     = 3'd1,
      CSR_COEF_BOTTOM  = 3'd2,
      CSR_IMAGE_WIDTH  = 3'd3,
      CSR_IMAGE_HEIGHT = 3'd4
   } csr_index_type;

   localparam logic [COEF_ROW_BITS-1:0] COEF_TOP_RESET    = 48'h0;
   localparam logic [COEF_ROW_BITS-1:0] COEF_MID_RESET    = 48'h10000;
   localparam logic [COEF_ROW_BITS-1:0] COEF_BOTTOM_RESET = 48'h0;
   localparam logic [SIZE_BITS-1:0]     SIZE_RESET        = 11'd1024;

   typedef struct packed {
      logic                         opcode;
      logic signed [PIXEL_BITS-1:0] pixel;
   } req_type;

   typedef struct packed {
      logic signed [SUM_BITS-1:0] out_value;
      logic [OUT_POS_BITS-1:0]    out_row;
      logic [OUT_POS_BITS-1:0]    out_col;
      logic                       last_of_frame;
   } rsp_type;

endpackage

`default_nettype wire

@@ hdl/cbconv_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cbconv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                                    clock,
   input  wire logic                                    we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                        wdata,
   input  wire logic                                    re,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                             rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ hdl/clamped_border_2d_convolution.sv @@
// Top level of the 3x3 convolution with replicated image borders.
//
//  Channel   Ports                          Direction  Moves
//  request   req_valid req_ready req_data   in         one pixel or flush tick
//  response  rsp_valid rsp_ready rsp_data   out        one output pixel
//  csr       csr_we csr_addr csr_wdata      in         one register write
//
// One item is taken every cycle unless the response stalls; after the item that completes
// its window, a result passes the line store read, window, multiply and two add registers.
// Reset clears the control state; the line stores hold no reset value and are
// written before they are read in every frame.
// A stalled response holds the whole pipeline, and req_ready follows it.
`default_nettype none

module clamped_border_2d_convolution #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire cbconv_pkg::req_type                    req_data,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output cbconv_pkg::rsp_type                         rsp_data,
   input  wire logic                                   csr_we,
   input  wire logic [cbconv_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  wire logic [cbconv_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   import cbconv_pkg::*;

   localparam int WB = $clog2(MAX_WIDTH + 1);
   localparam int CB = $clog2(MAX_WIDTH);
   localparam int HB = $clog2(MAX_HEIGHT + 1);
   localparam int RB = $clog2(MAX_HEIGHT + 2);
   localparam int OB = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   logic [COEF_ROW_BITS-1:0] coef_ff [TAPS];
   logic [SIZE_BITS-1:0]     width_reg_ff;
   logic [SIZE_BITS-1:0]     height_reg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[0]    <= COEF_TOP_RESET;
         coef_ff[1]    <= COEF_MID_RESET;
         coef_ff[2]    <= COEF_BOTTOM_RESET;
         width_reg_ff  <= SIZE_RESET;
         height_reg_ff <= SIZE_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_COEF_TOP:     coef_ff[0]    <= csr_wdata;
            CSR_COEF_MID:     coef_ff[1]    <= csr_wdata;
            CSR_COEF_BOTTOM:  coef_ff[2]    <= csr_wdata;
            CSR_IMAGE_WIDTH:  width_reg_ff  <= csr_wdata[SIZE_BITS-1:0];
            CSR_IMAGE_HEIGHT: height_reg_ff <= csr_wdata[SIZE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Frame control and position counters.
   logic          busy_ff;
   logic [WB-1:0] fw_ff;
   logic [HB-1:0] fh_ff;
   logic [RB-1:0] ri_ff;
   logic [CB-1:0] ci_ff;
   logic [OB-1:0] orow_ff;
   logic [CB-1:0] oc_ff;

   logic          adv;
   logic          take;
   logic          feeding;
   logic          out_on;
   logic          col_wrap;
   logic          oc_wrap;
   logic          out_last;
   logic [WB-1:0] clamp_w;
   logic [HB-1:0] clamp_h;
   logic [WB-1:0] cur_fw;
   logic [HB-1:0] cur_fh;
   logic          out_valid_ff;

   always_comb begin
      if (width_reg_ff == '0) begin
         clamp_w = WB'(1);
      end else if (int'(width_reg_ff) > MAX_WIDTH) begin
         clamp_w = WB'(MAX_WIDTH);
      end else begin
         clamp_w = WB'(width_reg_ff);
      end
      if (height_reg_ff == '0) begin
         clamp_h = HB'(1);
      end else if (int'(height_reg_ff) > MAX_HEIGHT) begin
         clamp_h = HB'(MAX_HEIGHT);
      end else begin
         clamp_h = HB'(height_reg_ff);
      end
   end

   assign adv      = !out_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign cur_fw   = busy_ff ? fw_ff : clamp_w;
   assign cur_fh   = busy_ff ? fh_ff : clamp_h;
   assign feeding  = ri_ff < RB'(cur_fh);
   assign take     = req_valid && adv &&
                     (busy_ff ? !(feeding && req_data.opcode == OP_FLUSH)
                              : req_data.opcode == OP_PIXEL);
   assign out_on   = (ri_ff > RB'(1)) || (ri_ff == RB'(1) && ci_ff != '0);
   assign col_wrap = WB'(ci_ff) == cur_fw - WB'(1);
   assign oc_wrap  = WB'(oc_ff) == cur_fw - WB'(1);
   assign out_last = out_on && oc_wrap && (HB'(orow_ff) == cur_fh - HB'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fw_ff   <= '0;
         fh_ff   <= '0;
         ri_ff   <= '0;
         ci_ff   <= '0;
         orow_ff <= '0;
         oc_ff   <= '0;
      end else if (take) begin
         fw_ff <= cur_fw;
         fh_ff <= cur_fh;
         if (out_last) begin
            busy_ff <= 1'b0;
            ri_ff   <= '0;
            ci_ff   <= '0;
            orow_ff <= '0;
            oc_ff   <= '0;
         end else begin
            busy_ff <= 1'b1;
            if (col_wrap) begin
               ci_ff <= '0;
               ri_ff <= ri_ff + RB'(1);
            end else begin
               ci_ff <= ci_ff + CB'(1);
            end
            if (out_on) begin
               if (oc_wrap) begin
                  oc_ff   <= '0;
                  orow_ff <= orow_ff + OB'(1);
               end else begin
                  oc_ff <= oc_ff + CB'(1);
               end
            end
         end
      end
   end

   // Stage 1: line store data arrives, the column of three rows is formed.
   logic                         v1_ff;
   logic signed [PIXEL_BITS-1:0] pix1_ff;
   logic [CB-1:0]                ci1_ff;
   logic                         top1_ff;
   logic                         virt1_ff;
   logic                         out1_ff;
   logic [OB-1:0]                orow1_ff;
   logic [CB-1:0]                oc1_ff;
   logic                         last1_ff;
   logic                         cf1_ff;
   logic                         cl1_ff;
   logic                         fwd_ff;
   logic [PIXEL_BITS-1:0]        fwd1_ff;
   logic [PIXEL_BITS-1:0]        fwd2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         fwd_ff <= 1'b0;
      end else if (adv) begin
         v1_ff  <= take;
         fwd_ff <= v1_ff && (ci1_ff == ci_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pix1_ff  <= req_data.pixel;
         ci1_ff   <= ci_ff;
         top1_ff  <= ri_ff == '0;
         virt1_ff <= !feeding;
         out1_ff  <= out_on;
         orow1_ff <= orow_ff;
         oc1_ff   <= oc_ff;
         last1_ff <= out_last;
         cf1_ff   <= oc_ff == '0;
         cl1_ff   <= oc_wrap;
      end
   end

   logic [PIXEL_BITS-1:0] rd1;
   logic [PIXEL_BITS-1:0] rd2;
   logic [PIXEL_BITS-1:0] lb1;
   logic [PIXEL_BITS-1:0] lb2;
   logic [PIXEL_BITS-1:0] vcol [TAPS];
   logic                  lb_we;

   assign lb1     = fwd_ff ? fwd1_ff : rd1;
   assign lb2     = fwd_ff ? fwd2_ff : rd2;
   assign vcol[0] = top1_ff ? pix1_ff : lb2;
   assign vcol[1] = top1_ff ? pix1_ff : lb1;
   assign vcol[2] = virt1_ff ? lb1 : pix1_ff;
   assign lb_we   = adv && v1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         fwd1_ff <= vcol[2];
         fwd2_ff <= vcol[1];
      end
   end

   cbconv_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_near (
      .clock (clock),
      .we    (lb_we),
      .waddr (ci1_ff),
      .wdata (vcol[2]),
      .re    (adv),
      .raddr (ci_ff),
      .rdata (rd1)
   );

   cbconv_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_far (
      .clock (clock),
      .we    (lb_we),
      .waddr (ci1_ff),
      .wdata (vcol[1]),
      .re    (adv),
      .raddr (ci_ff),
      .rdata (rd2)
   );

   // Stage 2: the 3x3 window with the left and right columns clamped.
   logic [PIXEL_BITS-1:0] w0_ff [TAPS];
   logic [PIXEL_BITS-1:0] w1_ff [TAPS];
   logic [PIXEL_BITS-1:0] win2_ff [TAPS][TAPS];
   logic                  v2_ff;
   logic [OB-1:0]         orow2_ff;
   logic [CB-1:0]         oc2_ff;
   logic                  last2_ff;

   always_ff @(posedge clock) begin
      if (adv && v1_ff) begin
         for (int i = 0; i < TAPS; i++) begin
            w1_ff[i] <= w0_ff[i];
            w0_ff[i] <= vcol[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < TAPS; i++) begin
            win2_ff[i][0] <= cf1_ff ? w0_ff[i] : w1_ff[i];
            win2_ff[i][1] <= w0_ff[i];
            win2_ff[i][2] <= cl1_ff ? w0_ff[i] : vcol[i];
         end
         orow2_ff <= orow1_ff;
         oc2_ff   <= oc1_ff;
         last2_ff <= last1_ff;
      end
   end

   // Stage 3: nine products.
   logic signed [PROD_BITS-1:0] prod3_ff [TAPS][TAPS];
   logic                        v3_ff;
   logic [OB-1:0]               orow3_ff;
   logic [CB-1:0]               oc3_ff;
   logic                        last3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < TAPS; i++) begin
            for (int j = 0; j < TAPS; j++) begin
               prod3_ff[i][j] <= $signed(win2_ff[i][j]) *
                                 $signed(coef_ff[i][COEF_BITS*j +: COEF_BITS]);
            end
         end
         orow3_ff <= orow2_ff;
         oc3_ff   <= oc2_ff;
         last3_ff <= last2_ff;
      end
   end

   // Stage 4: one sum per kernel row.
   logic signed [ROW_SUM_BITS-1:0] rsum4_ff [TAPS];
   logic                           v4_ff;
   logic [OB-1:0]                  orow4_ff;
   logic [CB-1:0]                  oc4_ff;
   logic                           last4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < TAPS; i++) begin
            rsum4_ff[i] <= ROW_SUM_BITS'(prod3_ff[i][0]) + ROW_SUM_BITS'(prod3_ff[i][1])
                         + ROW_SUM_BITS'(prod3_ff[i][2]);
         end
         orow4_ff <= orow3_ff;
         oc4_ff   <= oc3_ff;
         last4_ff <= last3_ff;
      end
   end

   // Output register.
   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         v2_ff        <= v1_ff && out1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         out_valid_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff.out_value     <= SUM_BITS'(rsum4_ff[0]) + SUM_BITS'(rsum4_ff[1])
                               + SUM_BITS'(rsum4_ff[2]);
         rsp_ff.out_row       <= OUT_POS_BITS'(orow4_ff);
         rsp_ff.out_col       <= OUT_POS_BITS'(oc4_ff);
         rsp_ff.last_of_frame <= last4_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = rsp_ff;

   a_reset_empty: assert property (@(posedge clock) reset |=> !out_valid_ff)
      else $error("response valid after reset");

   a_idle_counters: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (ri_ff == '0 && ci_ff == '0 && oc_ff == '0 && orow_ff == '0))
      else $error("position counters not cleared while idle");

   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      take && out_last |=> !busy_ff)
      else $error("frame did not end after its last output");

   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> ri_ff <= RB'(fh_ff) + RB'(1))
      else $error("input row counter ran past the drain rows");

endmodule

`default_nettype wire
